FILE: rtl/mce_pkg.sv
package mce_pkg;

    // Element lengths in dit units
    localparam logic [5:0] DIT_UNITS      = 6'd1;
    localparam logic [5:0] DAH_UNITS      = 6'd3;
    localparam logic [5:0] ELEM_GAP_UNITS = 6'd1;

    // Gap register reset values
    localparam logic [5:0] LETTER_GAP_RESET = 6'd3;
    localparam logic [5:0] WORD_GAP_RESET   = 6'd7;

    // Configuration register indexes
    localparam int        CFG_INDEX_W    = 4;
    localparam logic [3:0] CFG_LETTER_GAP = 4'd0;
    localparam logic [3:0] CFG_WORD_GAP   = 4'd1;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic {
        KIND_SYMBOL,
        KIND_SPACE
    } t_kind;

    // One classified character: element count and dah mask (bit 0 sent first)
    typedef struct packed {
        t_kind      kind;
        logic [2:0] len;
        logic [4:0] pat;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_EGAP,
        ST_WORD,
        ST_LETTER
    } t_state;

    // {len, dah mask}
    localparam logic [7:0] LETTER_TABLE [26] = '{
        {3'd2, 5'b00010}, // A
        {3'd4, 5'b00001}, // B
        {3'd4, 5'b00101}, // C
        {3'd3, 5'b00001}, // D
        {3'd1, 5'b00000}, // E
        {3'd4, 5'b00100}, // F
        {3'd3, 5'b00011}, // G
        {3'd4, 5'b00000}, // H
        {3'd2, 5'b00000}, // I
        {3'd4, 5'b01110}, // J
        {3'd3, 5'b00101}, // K
        {3'd4, 5'b00010}, // L
        {3'd2, 5'b00011}, // M
        {3'd2, 5'b00001}, // N
        {3'd3, 5'b00111}, // O
        {3'd4, 5'b00110}, // P
        {3'd4, 5'b01011}, // Q
        {3'd3, 5'b00010}, // R
        {3'd3, 5'b00000}, // S
        {3'd1, 5'b00001}, // T
        {3'd3, 5'b00100}, // U
        {3'd4, 5'b01000}, // V
        {3'd3, 5'b00110}, // W
        {3'd4, 5'b01001}, // X
        {3'd4, 5'b01101}, // Y
        {3'd4, 5'b00011}  // Z
    };

    localparam logic [4:0] DIGIT_TABLE [10] = '{
        5'b11111, // 0
        5'b11110, // 1
        5'b11100, // 2
        5'b11000, // 3
        5'b10000, // 4
        5'b00000, // 5
        5'b00001, // 6
        5'b00011, // 7
        5'b00111, // 8
        5'b01111  // 9
    };

    localparam logic [2:0] DIGIT_LEN = 3'd5;

endpackage

FILE: rtl/mce_front.sv
module mce_front (
    input  logic           i_accept,
    input  logic [7:0]     i_character,
    output logic           o_push,
    output mce_pkg::t_item o_item
);

    logic [7:0] w_off_upper;
    logic [7:0] w_off_lower;
    logic [7:0] w_off_digit;
    logic       w_upper;
    logic       w_lower;
    logic       w_digit;
    logic       w_space;
    logic [7:0] w_letter;

    assign w_off_upper = i_character - mce_pkg::CH_UPPER_A;
    assign w_off_lower = i_character - mce_pkg::CH_LOWER_A;
    assign w_off_digit = i_character - mce_pkg::CH_DIGIT_0;

    assign w_upper = (i_character >= mce_pkg::CH_UPPER_A) && (i_character <= mce_pkg::CH_UPPER_Z);
    assign w_lower = (i_character >= mce_pkg::CH_LOWER_A) && (i_character <= mce_pkg::CH_LOWER_Z);
    assign w_digit = (i_character >= mce_pkg::CH_DIGIT_0) && (i_character <= mce_pkg::CH_DIGIT_9);
    assign w_space = (i_character == mce_pkg::CH_SPACE);

    // case folded letter lookup
    assign w_letter = w_upper ? mce_pkg::LETTER_TABLE[w_off_upper[4:0]]
                              : mce_pkg::LETTER_TABLE[w_off_lower[4:0]];

    always_comb begin
        o_item.kind = mce_pkg::KIND_SYMBOL;
        o_item.len  = w_letter[7:5];
        o_item.pat  = w_letter[4:0];
        if (w_digit) begin
            o_item.len = mce_pkg::DIGIT_LEN;
            o_item.pat = mce_pkg::DIGIT_TABLE[w_off_digit[3:0]];
        end else if (w_space) begin
            o_item.kind = mce_pkg::KIND_SPACE;
            o_item.len  = 3'd0;
            o_item.pat  = 5'd0;
        end
    end

    // unknown codes are taken and dropped
    assign o_push = i_accept && (w_upper || w_lower || w_digit || w_space);

endmodule

FILE: rtl/mce_queue.sv
module mce_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mce_pkg::t_item i_item,
    input  logic           i_pop,
    output mce_pkg::t_item o_item,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    mce_pkg::t_item r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/mce_back.sv
module mce_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [5:0]     i_letter_gap,
    input  logic [5:0]     i_word_gap,
    input  logic           i_empty,
    input  mce_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_strobe,
    output logic           o_key_down,
    output logic [5:0]     o_duration_units,
    output logic           o_last_element
);

    mce_pkg::t_state r_state, n_state;
    logic [2:0] r_left, n_left;
    logic [4:0] r_pat, n_pat;
    logic       r_strobe, n_strobe;
    logic       r_key, n_key;
    logic [5:0] r_dur, n_dur;
    logic       r_last, n_last;

    logic [5:0] w_letter_gap;
    logic [5:0] w_word_gap;
    logic       w_load;

    // a zero gap register counts as one unit
    assign w_letter_gap = (i_letter_gap == 6'd0) ? 6'd1 : i_letter_gap;
    assign w_word_gap   = (i_word_gap == 6'd0) ? 6'd1 : i_word_gap;

    // next character may start right behind the letter gap
    assign w_load = ((r_state == mce_pkg::ST_IDLE) || (r_state == mce_pkg::ST_LETTER))
                    && !i_empty;
    assign o_pop  = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mce_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_pat  <= n_pat;
        r_key  <= n_key;
        r_dur  <= n_dur;
        r_last <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_pat    = r_pat;
        n_strobe = 1'b0;
        n_key    = 1'b0;
        n_dur    = mce_pkg::ELEM_GAP_UNITS;
        n_last   = 1'b0;
        unique case (r_state)
            mce_pkg::ST_IDLE: begin
                n_state = mce_pkg::ST_IDLE;
            end
            mce_pkg::ST_MARK: begin
                n_strobe = 1'b1;
                n_key    = 1'b1;
                n_dur    = r_pat[0] ? mce_pkg::DAH_UNITS : mce_pkg::DIT_UNITS;
                n_left   = r_left - 3'd1;
                n_pat    = r_pat >> 1;
                n_state  = (r_left == 3'd1) ? mce_pkg::ST_LETTER : mce_pkg::ST_EGAP;
            end
            mce_pkg::ST_EGAP: begin
                n_strobe = 1'b1;
                n_state  = mce_pkg::ST_MARK;
            end
            mce_pkg::ST_WORD: begin
                n_strobe = 1'b1;
                n_dur    = w_word_gap;
                n_state  = mce_pkg::ST_LETTER;
            end
            mce_pkg::ST_LETTER: begin
                n_strobe = 1'b1;
                n_dur    = w_letter_gap;
                n_last   = 1'b1;
                n_state  = mce_pkg::ST_IDLE;
            end
            default: begin
                n_state = mce_pkg::ST_IDLE;
            end
        endcase
        if (w_load) begin
            n_left  = i_item.len;
            n_pat   = i_item.pat;
            n_state = (i_item.kind == mce_pkg::KIND_SPACE) ? mce_pkg::ST_WORD
                                                           : mce_pkg::ST_MARK;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_key_down       = r_key;
    assign o_duration_units = r_dur;
    assign o_last_element   = r_last;

endmodule

FILE: rtl/morse_code_element_encoder.sv
// Morse element encoder. Pulse start with an ASCII code while busy is low;
// letters (either case), digits and space are encoded, anything else is taken
// and silently dropped. Each result is a key-down or key-up run with its
// length in dit units, shown for exactly one cycle with o_strobe high; the
// receiver cannot stall, so it must capture every strobe. Results of one
// character come out back to back, one per cycle, the last one (the letter
// gap) flagged by o_last_element. A character of n elements gives 2n results
// and a space gives two; the sequencer, at one result per cycle while it has a
// character, sets the throughput. When the sequencer is free, a character from
// start passes the queue, the sequencer state and the result registers in turn.
// A small character queue sits between the classifier and the sequencer;
// busy is high only while that queue is full.
// Gap registers are written over the cfg channel (always ready) and must only
// be changed while no character is in flight. A gap value of zero acts as one.
module morse_code_element_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // character command
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       i_character,
    // gap register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mce_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [5:0]                       i_cfg_data,
    // element results
    output logic                             o_strobe,
    output logic                             o_key_down,
    output logic [5:0]                       o_duration_units,
    output logic                             o_last_element
);

    logic [5:0] r_letter_gap;
    logic [5:0] r_word_gap;

    logic           w_accept;
    logic           w_push;
    mce_pkg::t_item w_front_item;
    mce_pkg::t_item w_head_item;
    logic           w_empty;
    logic           w_full;
    logic           w_pop;

    // Gap registers; writes to unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter_gap <= mce_pkg::LETTER_GAP_RESET;
            r_word_gap   <= mce_pkg::WORD_GAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == mce_pkg::CFG_LETTER_GAP) begin
                r_letter_gap <= i_cfg_data;
            end else if (i_cfg_index == mce_pkg::CFG_WORD_GAP) begin
                r_word_gap <= i_cfg_data;
            end
        end
    end

    // Front: take the character and look up its pattern
    assign busy     = w_full;
    assign w_accept = start && !busy;

    mce_front u_front (
        .i_accept    (w_accept),
        .i_character (i_character),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    // Queue of classified characters
    mce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Back: element sequencer, one result per cycle while it has a character
    mce_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_letter_gap     (r_letter_gap),
        .i_word_gap       (r_word_gap),
        .i_empty          (w_empty),
        .i_item           (w_head_item),
        .o_pop            (w_pop),
        .o_strobe         (o_strobe),
        .o_key_down       (o_key_down),
        .o_duration_units (o_duration_units),
        .o_last_element   (o_last_element)
    );

    // Checks

    // every run has a nonzero length
    a_dur_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_duration_units != 6'd0))
        else $error("zero length element");

    // a tone is never the final element of a character
    a_mark_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_key_down) |-> !o_last_element)
        else $error("tone flagged as last element");

    // every tone is followed at once by a silence transfer
    a_mark_then_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_key_down) |=> (o_strobe && !o_key_down))
        else $error("tone not followed by gap");

    // the sequencer never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

endmodule
